/* rtl/core/npds_pkg.sv */
// Package for the near-point de-duplicating store.
// Holds shared constants, register indexes, the controller state type and the
// status struct passed from the distance pipeline. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package npds_pkg;

  // Default build sizes.
  localparam int NPDS_STORE_DEPTH = 256;
  localparam int NPDS_COORD_BITS  = 24;

  // Register widths and reset values.
  localparam int DIST_BITS   = 50;
  localparam int LIMIT_BITS  = 8;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [DIST_BITS-1:0]  CLOSE_DIST_SQ_RESET = DIST_BITS'(262144);
  localparam logic [LIMIT_BITS-1:0] RETAIN_LIMIT_RESET  = LIMIT_BITS'(200);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLOSE_DIST_SQ = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_RETAIN_LIMIT  = CFG_IDX_BITS'(1);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } npds_state_t;

  // Status of the distance pipeline towards the controller.
  typedef struct packed {
    logic busy;     // any stage holds a comparison in flight
    logic hit_vld;  // a comparison result is present this cycle
    logic hit;      // that result is closer than the threshold
  } npds_dist_stat_t;

endpackage

`default_nettype wire

/* rtl/core/npds_ram.sv */
// Single-port-write, single-port-read synchronous memory for stored points.
// Read data is registered, appearing in the cycle after the read request. Uses npds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npds_ram #(
  parameter int DEPTH = npds_pkg::NPDS_STORE_DEPTH,
  parameter int WIDTH = 2 * npds_pkg::NPDS_COORD_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  import npds_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/npds_dist.sv */
// Three-stage squared-distance pipeline: absolute differences, squares, then
// sum and threshold compare. Uses npds_pkg for the status struct and widths.
`timescale 1ns / 1ps
`default_nettype none

module npds_dist #(
  parameter int COORD_BITS = npds_pkg::NPDS_COORD_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_vld,
  input  wire logic signed [COORD_BITS-1:0]          px,
  input  wire logic signed [COORD_BITS-1:0]          py,
  input  wire logic signed [COORD_BITS-1:0]          qx,
  input  wire logic signed [COORD_BITS-1:0]          qy,
  input  wire logic        [npds_pkg::DIST_BITS-1:0] thresh,
  output npds_pkg::npds_dist_stat_t                  stat
);

  import npds_pkg::*;

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = (SQ_W + 1 > DIST_BITS) ? SQ_W + 1 : DIST_BITS;

  logic                  v1, v2, v3;
  logic [COORD_BITS-1:0] dx, dy;
  logic [SQ_W-1:0]       sqx, sqy;
  logic                  hit;

  logic [COORD_BITS:0]   dxw, dyw;
  logic [COORD_BITS:0]   dxa, dya;
  logic [SQ_W-1:0]       sqx_next, sqy_next;
  logic [SQ_W:0]         sum;

  // Differences in one extra bit; the magnitude always fits the coordinate width.
  always_comb begin
    dxw = {px[COORD_BITS-1], px} - {qx[COORD_BITS-1], qx};
    dyw = {py[COORD_BITS-1], py} - {qy[COORD_BITS-1], qy};
    dxa = dxw[COORD_BITS] ? (~dxw + 1'b1) : dxw;
    dya = dyw[COORD_BITS] ? (~dyw + 1'b1) : dyw;
  end

  // One unsigned multiplier per axis, result in double width.
  always_comb begin
    sqx_next = dx * dx;
    sqy_next = dy * dy;
  end

  // Sum cannot overflow here, so no saturation is needed before the compare.
  assign sum = {1'b0, sqx} + {1'b0, sqy};

  // Valid chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Data stages.
  always_ff @(posedge clk) begin
    dx  <= dxa[COORD_BITS-1:0];
    dy  <= dya[COORD_BITS-1:0];
    sqx <= sqx_next;
    sqy <= sqy_next;
    hit <= SUM_W'(sum) < SUM_W'(thresh);
  end

  always_comb begin
    stat.busy    = v1 | v2 | v3;
    stat.hit_vld = v3;
    stat.hit     = hit;
  end

endmodule

`default_nettype wire

/* rtl/core/near_point_dedup_store.sv */
// Near-point de-duplicating store: top level with controller and registers.
// Instantiates npds_ram and npds_dist; uses npds_pkg.
//
// Each offered point is checked against every live point of a FIFO-ordered
// store held in one synchronous memory, one stored point read per cycle and
// fed through a three-stage squared-distance pipeline. An item occupies the
// block from its transfer to the earliest next transfer while the N stored
// points left after any eviction are scanned; the eight-bit retain limit
// keeps N at 255 or below after eviction. The single memory read port sets
// that occupancy; a result still waiting in the output register adds its
// wait on top. in_stall stays high from the transfer of an item until its
// result is written to the output register, which then waits for the
// consumer on its own while the next item is taken. No clearing pass is run
// after reset; only live entries are ever read. Configuration writes are
// taken in every cycle outside reset.
`timescale 1ns / 1ps
`default_nettype none

module near_point_dedup_store #(
  parameter int STORE_DEPTH = npds_pkg::NPDS_STORE_DEPTH,
  parameter int COORD_BITS  = npds_pkg::NPDS_COORD_BITS
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  // Configuration write channel
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [npds_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  wire logic [npds_pkg::DIST_BITS-1:0]            cfg_data,
  // Input point channel
  input  wire logic                                      in_valid,
  output logic                                           in_stall,
  input  wire logic signed [COORD_BITS-1:0]              point_x,
  input  wire logic signed [COORD_BITS-1:0]              point_y,
  // Result channel
  output logic                                           out_valid,
  input  wire logic                                      out_stall,
  output logic                                           accepted,
  output logic                                           evicted,
  output logic                                           store_full,
  output logic [$clog2(STORE_DEPTH+1)-1:0]               point_count
);

  import npds_pkg::*;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > LIMIT_BITS) ? CNT_W : LIMIT_BITS;
  localparam int WORD_W = 2 * COORD_BITS;

  npds_state_t state, state_next;

  // Registers
  logic [DIST_BITS-1:0]         close_dist_sq;
  logic [LIMIT_BITS-1:0]        retain_limit;
  logic signed [COORD_BITS-1:0] px, py;
  logic [ADDR_W-1:0]            oldest;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             scan_left;
  logic [ADDR_W-1:0]            rd_ptr;
  logic                         rd_vld;
  logic                         close_flag;
  logic                         evict_flag;

  // Combinational control
  logic                  take_item;
  logic                  do_evict;
  logic                  ram_re;
  logic                  ram_we;
  logic                  out_load;
  logic                  is_full;
  logic [ADDR_W-1:0]     oldest_inc;
  logic [ADDR_W-1:0]     rd_ptr_inc;
  logic [ADDR_W:0]       wsum;
  logic [ADDR_W-1:0]     waddr;
  logic [WORD_W-1:0]     rdata;
  npds_dist_stat_t       dstat;

  // Memory holding {x, y} for each stored point.
  npds_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({px, py}),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  // Distance pipeline against the held offered point.
  npds_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk    (clk),
    .rst    (rst),
    .in_vld (rd_vld),
    .px     (px),
    .py     (py),
    .qx     (rdata[WORD_W-1:COORD_BITS]),
    .qy     (rdata[COORD_BITS-1:0]),
    .thresh (close_dist_sq),
    .stat   (dstat)
  );

  // Ring pointer arithmetic; the append slot is one compare and subtract.
  always_comb begin
    oldest_inc = (oldest == ADDR_W'(STORE_DEPTH - 1)) ? '0 : oldest + 1'b1;
    rd_ptr_inc = (rd_ptr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    wsum       = {1'b0, oldest} + (ADDR_W + 1)'(count);
    waddr      = (wsum >= (ADDR_W + 1)'(STORE_DEPTH))
               ? ADDR_W'(wsum - (ADDR_W + 1)'(STORE_DEPTH))
               : ADDR_W'(wsum);
    is_full    = (count == CNT_W'(STORE_DEPTH));
    do_evict   = CMP_W'(count) > CMP_W'(retain_limit);
  end

  // Next state and controls.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    take_item  = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    cfg_ready  = !rst;
    unique case (state)
      ST_IDLE: begin
        in_stall = rst;
        if (in_valid && !rst) begin
          take_item  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram_re = (scan_left != '0);
        if (scan_left == '0 && !rd_vld && !dstat.busy) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          ram_we     = !close_flag && !is_full;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      close_dist_sq <= CLOSE_DIST_SQ_RESET;
      retain_limit  <= RETAIN_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CLOSE_DIST_SQ) begin
        close_dist_sq <= cfg_data;
      end else if (cfg_index == CFG_RETAIN_LIMIT) begin
        retain_limit <= cfg_data[LIMIT_BITS-1:0];
      end
    end
  end

  // Store bookkeeping: eviction on transfer, append on decision.
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest     <= '0;
      count      <= '0;
      scan_left  <= '0;
      rd_vld     <= 1'b0;
      close_flag <= 1'b0;
      evict_flag <= 1'b0;
    end else begin
      rd_vld <= ram_re;
      if (take_item) begin
        close_flag <= 1'b0;
        evict_flag <= do_evict;
        if (do_evict) begin
          oldest    <= oldest_inc;
          count     <= count - 1'b1;
          scan_left <= count - 1'b1;
        end else begin
          scan_left <= count;
        end
      end else begin
        if (ram_re) begin
          scan_left <= scan_left - 1'b1;
        end
        if (dstat.hit_vld && dstat.hit) begin
          close_flag <= 1'b1;
        end
        if (ram_we) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  // Offered point and read pointer.
  always_ff @(posedge clk) begin
    if (take_item) begin
      px     <= point_x;
      py     <= point_y;
      rd_ptr <= do_evict ? oldest_inc : oldest;
    end else if (ram_re) begin
      rd_ptr <= rd_ptr_inc;
    end
  end

  // Output register, freed by a transfer on the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accepted    <= !close_flag && !is_full;
      evicted     <= evict_flag;
      store_full  <= !close_flag && is_full;
      point_count <= (!close_flag && !is_full) ? count + 1'b1 : count;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STORE_DEPTH))
    else $error("stored count exceeds store depth");

  a_write_after_scan: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_DECIDE) && (scan_left == '0) && !rd_vld && !dstat.busy)
    else $error("store written while a scan is in flight");

  a_item_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_SCAN))
    else $error("transferred item did not start a scan");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && store_full))
    else $error("result both accepted and refused as full");

  a_no_read_outside_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state == ST_SCAN))
    else $error("memory read outside a scan");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for the near-point de-duplicating store.
// Drives points and register writes, predicts every result and checks each transfer.
// Depends on npds_pkg and near_point_dedup_store.
`timescale 1ns / 1ps

module tb;
  import npds_pkg::*;

  localparam int DEPTH       = NPDS_STORE_DEPTH;
  localparam int CW          = NPDS_COORD_BITS;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int HOLD_CYCLES = 600;
  localparam int QUIET_LIMIT = 4000;

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  // Register indexes that the block does not implement.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_2 = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_3 = CFG_IDX_BITS'(3);

  typedef struct packed {
    logic             accepted;
    logic             evicted;
    logic             full;
    logic [CNT_W-1:0] count;
  } store_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [DIST_BITS-1:0]    cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic signed [CW-1:0]    point_x   = '0;
  logic signed [CW-1:0]    point_y   = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    accepted;
  logic                    evicted;
  logic                    store_full;
  logic [CNT_W-1:0]        point_count;

  // Own copy of the store contents and registers, used for prediction.
  logic signed [CW-1:0] kept_x [DEPTH];
  logic signed [CW-1:0] kept_y [DEPTH];
  int unsigned          kept_oldest;
  int unsigned          kept_count;
  logic [DIST_BITS-1:0] kept_close_sq;
  logic [LIMIT_BITS-1:0] kept_limit;

  store_outcome_t    expected_outcomes [$];
  logic [2*CW-1:0]   recent_pts [$];
  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles   = 0;
  bit                idle_on        = 1'b1;
  bit                hold_req       = 1'b0;

  near_point_dedup_store #(
    .STORE_DEPTH(DEPTH),
    .COORD_BITS (CW)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .accepted   (accepted),
    .evicted    (evicted),
    .store_full (store_full),
    .point_count(point_count)
  );

  always #6 clk = ~clk;

  // Squared Euclidean distance, saturating at the top of 64 bits.
  function automatic logic [63:0] dist_sq_of(input logic signed [CW-1:0] ax,
                                             input logic signed [CW-1:0] ay,
                                             input logic signed [CW-1:0] bx,
                                             input logic signed [CW-1:0] by);
    longint      dx;
    longint      dy;
    logic [63:0] ux;
    logic [63:0] uy;
    logic [63:0] sx;
    logic [63:0] sy;
    logic [64:0] sum;
    dx  = longint'(ax) - longint'(bx);
    dy  = longint'(ay) - longint'(by);
    ux  = (dx < 0) ? 64'(-dx) : 64'(dx);
    uy  = (dy < 0) ? 64'(-dy) : 64'(dy);
    sx  = ux * ux;
    sy  = uy * uy;
    sum = {1'b0, sx} + {1'b0, sy};
    return sum[64] ? {64{1'b1}} : sum[63:0];
  endfunction

  // Evict, scan for a close point, append; returns the result of one point.
  function automatic store_outcome_t predict_outcome(input logic signed [CW-1:0] px,
                                                     input logic signed [CW-1:0] py);
    store_outcome_t res;
    bit             near;
    int unsigned    i;
    int unsigned    slot;
    res  = '0;
    near = 1'b0;
    if (kept_count > kept_limit) begin
      kept_oldest = (kept_oldest + 1) % DEPTH;
      kept_count--;
      res.evicted = 1'b1;
    end
    for (i = 0; i < kept_count && !near; i++) begin
      slot = (kept_oldest + i) % DEPTH;
      if (dist_sq_of(px, py, kept_x[slot], kept_y[slot]) < 64'(kept_close_sq))
        near = 1'b1;
    end
    if (!near) begin
      if (kept_count >= DEPTH) begin
        res.full = 1'b1;
      end else begin
        slot = (kept_oldest + kept_count) % DEPTH;
        kept_x[slot] = px;
        kept_y[slot] = py;
        kept_count++;
        res.accepted = 1'b1;
      end
    end
    res.count = CNT_W'(kept_count);
    return res;
  endfunction

  // Random point: mostly anywhere, often close to or on a recent point, sometimes a corner.
  function automatic logic [2*CW-1:0] choose_point();
    logic [2*CW-1:0]      base;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    int                   span;
    int                   pick;
    pick = $urandom_range(0, 9);
    if (recent_pts.size() == 0 && pick >= 5 && pick <= 8)
      pick = 0;
    case (pick)
      5, 6, 7: begin
        base = recent_pts[$urandom_range(0, recent_pts.size() - 1)];
        bx   = base[2*CW-1:CW];
        by   = base[CW-1:0];
        span = ($urandom_range(0, 1) != 0) ? 512 : 4096;
        return {CW'(longint'(bx) + $urandom_range(0, 2 * span) - span),
                CW'(longint'(by) + $urandom_range(0, 2 * span) - span)};
      end
      8:       return recent_pts[$urandom_range(0, recent_pts.size() - 1)];
      9:       return {($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN,
                       ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN};
      default: return {CW'($urandom), CW'($urandom)};
    endcase
  endfunction

  // Offer one point and wait for its transfer; then record what it should produce.
  task automatic offer_point(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x  <= px;
    point_y  <= py;
    do @(posedge clk); while (in_stall);
    expected_outcomes.insert(expected_outcomes.size(), predict_outcome(px, py));
    recent_pts.insert(recent_pts.size(), {px, py});
    if (recent_pts.size() > 16)
      recent_pts.pop_front();
  endtask

  task automatic offer_random_points(input int unsigned n);
    logic [2*CW-1:0] pt;
    repeat (n) begin
      pt = choose_point();
      offer_point(pt[2*CW-1:CW], pt[CW-1:0]);
    end
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_outcomes.size() != 0);
  endtask

  // Two register writes back to back; valid stays high between them.
  task automatic write_reg_pair(input logic [CFG_IDX_BITS-1:0] idx_a,
                                input logic [DIST_BITS-1:0]    val_a,
                                input logic [CFG_IDX_BITS-1:0] idx_b,
                                input logic [DIST_BITS-1:0]    val_b);
    logic [CFG_IDX_BITS-1:0] idx [2];
    logic [DIST_BITS-1:0]    val [2];
    int                      k;
    idx[0] = idx_a;
    idx[1] = idx_b;
    val[0] = val_a;
    val[1] = val_b;
    for (k = 0; k < 2; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx[k])
        CFG_CLOSE_DIST_SQ: kept_close_sq = val[k];
        CFG_RETAIN_LIMIT:  kept_limit    = val[k][LIMIT_BITS-1:0];
        default:           ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Reset values, an empty store, duplicates on and just off the threshold, coordinate extremes.
  task automatic test_directed_edges();
    offer_point(0, 0);
    offer_point(0, 0);
    offer_point(512, 0);
    offer_point(0, 511);
    offer_point(COORD_MAX, COORD_MAX);
    offer_point(COORD_MIN, COORD_MIN);
    offer_point(COORD_MAX, COORD_MIN);
    offer_point(COORD_MIN, COORD_MAX);
    offer_point(-1, -1);
    drain_results();
  endtask

  // A retain limit of zero evicts on every point while the store holds anything.
  task automatic test_zero_retain();
    write_reg_pair(CFG_CLOSE_DIST_SQ, DIST_BITS'(262144), CFG_RETAIN_LIMIT, '0);
    offer_point(100, 100);
    offer_point(100, 100);
    offer_point(-3000, 7000);
    drain_results();
  endtask

  // Zero and full-scale thresholds, masking of wide data, and writes to spare indexes.
  task automatic test_threshold_extremes();
    write_reg_pair(CFG_CLOSE_DIST_SQ, '0, CFG_RETAIN_LIMIT, DIST_BITS'(200));
    offer_point(-3000, 7000);
    offer_point(-3000, 7000);
    drain_results();
    write_reg_pair(CFG_CLOSE_DIST_SQ, '1, CFG_RETAIN_LIMIT, {{(DIST_BITS-8){1'b1}}, 8'hFF});
    offer_point(COORD_MAX, COORD_MIN);
    offer_point(COORD_MIN, COORD_MAX);
    offer_point(0, 0);
    drain_results();
    write_reg_pair(CFG_CLOSE_DIST_SQ, DIST_BITS'(1) << (DIST_BITS - 1),
                   CFG_RETAIN_LIMIT, DIST_BITS'(1));
    offer_point(COORD_MAX, COORD_MAX);
    offer_point(0, 0);
    drain_results();
    write_reg_pair(CFG_SPARE_2, '1, CFG_SPARE_3, '0);
    offer_point(1234, -1234);
    drain_results();
  endtask

  // Fill the store to its depth with distinct points, then keep going so the oldest is dropped.
  task automatic test_store_fill();
    write_reg_pair(CFG_CLOSE_DIST_SQ, DIST_BITS'(1), CFG_RETAIN_LIMIT, DIST_BITS'(255));
    repeat (300) offer_point(CW'($urandom), CW'($urandom));
    drain_results();
  endtask

  // Several phases, each with its own threshold and retain limit.
  task automatic test_random_phases();
    logic [DIST_BITS-1:0] thresh_val;
    logic [DIST_BITS-1:0] limit;
    repeat (8) begin
      case ($urandom_range(0, 4))
        0:       thresh_val = '0;
        1:       thresh_val = DIST_BITS'(262144);
        2:       thresh_val = DIST_BITS'(1) << $urandom_range(4, 40);
        3:       thresh_val = DIST_BITS'({$urandom, $urandom});
        default: thresh_val = DIST_BITS'(1) << (DIST_BITS - 1);
      endcase
      case ($urandom_range(0, 5))
        0:       limit = DIST_BITS'(1);
        1:       limit = DIST_BITS'($urandom_range(2, 16));
        2:       limit = DIST_BITS'($urandom_range(50, 255));
        3:       limit = DIST_BITS'(255);
        4:       limit = DIST_BITS'(0);
        default: limit = DIST_BITS'(200);
      endcase
      if ($urandom_range(0, 1) != 0)
        write_reg_pair(CFG_CLOSE_DIST_SQ, thresh_val, CFG_RETAIN_LIMIT, limit);
      else
        write_reg_pair(CFG_RETAIN_LIMIT, limit, CFG_CLOSE_DIST_SQ, thresh_val);
      offer_random_points(100);
      drain_results();
    end
  endtask

  // Hold the receiver off for a long stretch while points keep being offered.
  task automatic test_backpressure();
    hold_req = 1'b1;
    offer_random_points(20);
    drain_results();
  endtask

  // Last part of the run: no idling on either side.
  task automatic test_steady_stream();
    idle_on = 1'b0;
    write_reg_pair(CFG_CLOSE_DIST_SQ, DIST_BITS'(262144), CFG_RETAIN_LIMIT, DIST_BITS'(40));
    offer_random_points(150);
    drain_results();
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : rx_side
    int unsigned held;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    store_outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: accepted=%0d evicted=%0d full=%0d count=%0d",
                   accepted, evicted, store_full, point_count);
      end else begin
        want = expected_outcomes.pop_front();
        if (accepted !== want.accepted || evicted !== want.evicted ||
            store_full !== want.full || point_count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected accepted=%0d evicted=%0d full=%0d count=%0d, got %0d %0d %0d %0d",
                     want.accepted, want.evicted, want.full, want.count,
                     accepted, evicted, store_full, point_count);
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    kept_oldest   = 0;
    kept_count    = 0;
    kept_close_sq = CLOSE_DIST_SQ_RESET;
    kept_limit    = RETAIN_LIMIT_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_zero_retain();
    test_threshold_extremes();
    test_store_fill();
    test_random_phases();
    test_backpressure();
    test_steady_stream();
    // Allow for a stray result after the last expected one.
    repeat (DEPTH + 16) @(posedge clk);
    if (mismatch_count == 0 && expected_outcomes.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/npds_pkg.sv
rtl/core/npds_ram.sv
rtl/core/npds_dist.sv
rtl/core/near_point_dedup_store.sv
tb/sv/tb.sv
